// ----- hw/rtl/sri_pkg.sv -----
`timescale 1ns / 1ps

package sri_pkg;

  // data memory geometry
  localparam int unsigned DATA_WORDS = 4096;
  localparam int unsigned DM_AW      = $clog2(DATA_WORDS);

  // register file geometry
  localparam int unsigned REG_COUNT  = 16;
  localparam int unsigned RF_AW      = $clog2(REG_COUNT);

  // port widths fixed by the instruction format
  localparam int unsigned MA_W       = 12;

  // program counter constants
  localparam logic [15:0] PC_RESET   = 16'd4000;
  localparam logic [15:0] PC_STEP    = 16'd4;

  // opcodes
  typedef enum logic [3:0] {
    CMD_MOVC  = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_AND   = 4'd4,
    CMD_OR    = 4'd5,
    CMD_XOR   = 4'd6,
    CMD_LOAD  = 4'd7,
    CMD_STORE = 4'd8,
    CMD_BZ    = 4'd9,
    CMD_BNZ   = 4'd10,
    CMD_JUMP  = 4'd11,
    CMD_HALT  = 4'd12
  } cmd_e;

  // outcome of one instruction, carried from execute to memory stage
  typedef struct packed {
    logic [15:0]      next_pc;
    logic             reg_write;
    logic [RF_AW-1:0] rf_idx;
    logic [31:0]      reg_value;
    logic             is_load;
    logic             mem_write;
    logic [DM_AW-1:0] dm_addr;
    logic [MA_W-1:0]  mem_addr;
    logic [31:0]      mem_value;
    logic             halted;
  } res_t;

endpackage

// ----- hw/rtl/sri_ram.sv -----
`timescale 1ns / 1ps

module sri_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/sri_exec.sv -----
`timescale 1ns / 1ps

module sri_exec (
  input  logic [3:0]                cmd_i,
  input  logic [sri_pkg::RF_AW-1:0] dest_i,
  input  logic [31:0]               opa_i,
  input  logic [31:0]               opb_i,
  input  logic signed [15:0]        imm_i,
  input  logic [15:0]               pc_i,
  input  logic                      zf_i,
  input  logic                      halt_i,
  output sri_pkg::res_t             res_o,
  output logic                      zf_o
);
  import sri_pkg::*;

  logic [31:0] imm32;
  logic [15:0] imm16;
  logic [31:0] add_res;
  logic [31:0] sub_res;
  logic [31:0] mul_res;
  logic [31:0] ld_sum;
  logic [31:0] st_sum;
  logic [31:0] jmp_sum;

  // operand arithmetic
  assign imm16   = imm_i;
  assign imm32   = {{16{imm_i[15]}}, imm16};
  assign add_res = opa_i + opb_i;
  assign sub_res = opa_i - opb_i;
  assign mul_res = opa_i * opb_i;
  assign ld_sum  = opa_i + imm32;
  assign st_sum  = opb_i + imm32;
  assign jmp_sum = opa_i + imm32;

  // decode and select
  always_comb begin
    res_o = '0;
    zf_o  = zf_i;
    if (halt_i) begin
      res_o.next_pc = pc_i;
      res_o.halted  = 1'b1;
    end else begin
      res_o.next_pc = pc_i + PC_STEP;
      unique case (cmd_e'(cmd_i))
        CMD_MOVC: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = imm32;
        end
        CMD_ADD: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = add_res;
          zf_o            = (add_res == '0);
        end
        CMD_SUB: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = sub_res;
          zf_o            = (sub_res == '0);
        end
        CMD_MUL: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = mul_res;
          zf_o            = (mul_res == '0);
        end
        CMD_AND: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = opa_i & opb_i;
        end
        CMD_OR: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = opa_i | opb_i;
        end
        CMD_XOR: begin
          res_o.reg_write = 1'b1;
          res_o.reg_value = opa_i ^ opb_i;
        end
        CMD_LOAD: begin
          res_o.reg_write = 1'b1;
          res_o.is_load   = 1'b1;
          res_o.dm_addr   = ld_sum[DM_AW-1:0];
          res_o.mem_addr  = MA_W'(ld_sum[DM_AW-1:0]);
        end
        CMD_STORE: begin
          res_o.mem_write = 1'b1;
          res_o.mem_value = opa_i;
          res_o.dm_addr   = st_sum[DM_AW-1:0];
          res_o.mem_addr  = MA_W'(st_sum[DM_AW-1:0]);
        end
        CMD_BZ: begin
          if (zf_i) begin
            res_o.next_pc = pc_i + imm16;
          end
        end
        CMD_BNZ: begin
          if (!zf_i) begin
            res_o.next_pc = pc_i + imm16;
          end
        end
        CMD_JUMP: begin
          res_o.next_pc = jmp_sum[15:0];
        end
        CMD_HALT: begin
          res_o.halted  = 1'b1;
          res_o.next_pc = pc_i;
        end
        default: begin
          // unused opcodes fall through to pc+4
        end
      endcase
      if (res_o.reg_write) begin
        res_o.rf_idx = dest_i;
      end
    end
  end

endmodule

// ----- hw/rtl/small_risc_instruction_executor_top.sv -----
`timescale 1ns / 1ps

// Executes one decoded instruction per word against its own register file,
// zero flag, data memory, program counter and halt mark, and returns one
// result word per instruction. Throughput is one instruction per cycle while
// out_ready_i does not hold results back. Each instruction passes the execute
// stage on the register file operands with the data memory access, then the
// memory stage where load data returns, then the output register. The register
// file and data memory each have a registered read port, so results of
// older instructions still in flight are bypassed into execute. After reset
// the data memory is zeroed one word per cycle, all DATA_WORDS (4096) words,
// during which in_ready_o stays low.
module small_risc_instruction_executor_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         cmd_i,
  input  logic [3:0]         dest_reg_i,
  input  logic [3:0]         src_a_reg_i,
  input  logic [3:0]         src_b_reg_i,
  input  logic signed [15:0] immediate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        next_pc_o,
  output logic               reg_write_o,
  output logic [3:0]         reg_index_o,
  output logic signed [31:0] reg_value_o,
  output logic               mem_write_o,
  output logic [11:0]        mem_addr_o,
  output logic signed [31:0] mem_value_o,
  output logic               halted_o
);
  import sri_pkg::*;

  localparam logic [DM_AW:0] CLR_DONE = (DM_AW + 1)'(DATA_WORDS);

  // stage enables
  logic en_out;
  logic en2;
  logic en1;

  // clearing pass
  logic [DM_AW:0] clr_cnt_q;
  logic           clr_active;

  // execute stage
  logic                    s1_vld_q;
  logic [3:0]              s1_cmd_q;
  logic [RF_AW-1:0]        s1_dest_q;
  logic [RF_AW-1:0]        s1_ra_q;
  logic [RF_AW-1:0]        s1_rb_q;
  logic signed [15:0]      s1_imm_q;

  // memory stage
  logic                    s2_vld_q;
  res_t                    s2_q;
  logic [31:0]             s2_value;

  // architectural state
  logic [15:0]             pc_q;
  logic                    zf_q;
  logic                    halt_q;

  // register file
  logic [REG_COUNT-1:0]    rf_vld_q;
  logic [RF_AW-1:0]        rf_raddr_a;
  logic [RF_AW-1:0]        rf_raddr_b;
  logic [31:0]             rf_rdata_a;
  logic [31:0]             rf_rdata_b;
  logic                    rfv_a_q;
  logic                    rfv_b_q;
  logic                    rf_we;
  logic                    wb_vld_q;
  logic [RF_AW-1:0]        wb_idx_q;
  logic [31:0]             wb_data_q;
  logic [31:0]             opa;
  logic [31:0]             opb;

  // data memory
  logic                    dm_we;
  logic [DM_AW-1:0]        dm_waddr;
  logic [31:0]             dm_wdata;
  logic [DM_AW-1:0]        dm_raddr;
  logic [31:0]             dm_rdata;
  logic                    st_we;

  // execute outcome
  res_t                    ex_res;
  logic                    ex_zf;

  // output register
  logic                    out_vld_q;
  logic [15:0]             out_pc_q;
  logic                    out_rw_q;
  logic [3:0]              out_ridx_q;
  logic [31:0]             out_rval_q;
  logic                    out_mw_q;
  logic [11:0]             out_maddr_q;
  logic [31:0]             out_mval_q;
  logic                    out_halt_q;

  // pipeline flow, bubbles collapse
  assign en_out     = !out_vld_q || out_ready_i;
  assign en2        = !s2_vld_q || en_out;
  assign en1        = !s1_vld_q || en2;
  assign clr_active = (clr_cnt_q != CLR_DONE);
  assign in_ready_o = en1 && !clr_active;

  // register file read, re-read held address while execute is stalled
  assign rf_raddr_a = en1 ? RF_AW'(src_a_reg_i) : s1_ra_q;
  assign rf_raddr_b = en1 ? RF_AW'(src_b_reg_i) : s1_rb_q;

  sri_ram #(
    .Width (32),
    .Depth (REG_COUNT)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rf_idx),
    .wdata_i (s2_value),
    .raddr_i (rf_raddr_a),
    .rdata_o (rf_rdata_a)
  );

  sri_ram #(
    .Width (32),
    .Depth (REG_COUNT)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_q.rf_idx),
    .wdata_i (s2_value),
    .raddr_i (rf_raddr_b),
    .rdata_o (rf_rdata_b)
  );

  // operand bypass: memory stage first, then the write of the last edge
  always_comb begin
    if (s2_vld_q && s2_q.reg_write && (s2_q.rf_idx == s1_ra_q)) begin
      opa = s2_value;
    end else if (wb_vld_q && (wb_idx_q == s1_ra_q)) begin
      opa = wb_data_q;
    end else begin
      opa = rfv_a_q ? rf_rdata_a : '0;
    end
    if (s2_vld_q && s2_q.reg_write && (s2_q.rf_idx == s1_rb_q)) begin
      opb = s2_value;
    end else if (wb_vld_q && (wb_idx_q == s1_rb_q)) begin
      opb = wb_data_q;
    end else begin
      opb = rfv_b_q ? rf_rdata_b : '0;
    end
  end

  sri_exec u_exec (
    .cmd_i  (s1_cmd_q),
    .dest_i (s1_dest_q),
    .opa_i  (opa),
    .opb_i  (opb),
    .imm_i  (s1_imm_q),
    .pc_i   (pc_q),
    .zf_i   (zf_q),
    .halt_i (halt_q),
    .res_o  (ex_res),
    .zf_o   (ex_zf)
  );

  // data memory, cleared after reset, then store port of execute
  assign st_we    = s1_vld_q && en2 && ex_res.mem_write;
  assign dm_we    = clr_active || st_we;
  assign dm_waddr = clr_active ? clr_cnt_q[DM_AW-1:0] : ex_res.dm_addr;
  assign dm_wdata = clr_active ? '0 : ex_res.mem_value;
  assign dm_raddr = en2 ? ex_res.dm_addr : s2_q.dm_addr;

  sri_ram #(
    .Width (32),
    .Depth (DATA_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // memory stage value and register write back
  assign s2_value = s2_q.is_load ? dm_rdata : s2_q.reg_value;
  assign rf_we    = s2_vld_q && en_out && s2_q.reg_write;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= PC_RESET;
      zf_q      <= 1'b0;
      halt_q    <= 1'b0;
      rf_vld_q  <= '0;
      rfv_a_q   <= 1'b0;
      rfv_b_q   <= 1'b0;
      wb_vld_q  <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (en1) begin
        s1_vld_q <= in_valid_i && in_ready_o;
      end
      if (en2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (en_out) begin
        out_vld_q <= s2_vld_q;
      end
      if (s1_vld_q && en2) begin
        pc_q   <= ex_res.next_pc;
        zf_q   <= ex_zf;
        halt_q <= ex_res.halted;
      end
      if (rf_we) begin
        rf_vld_q[s2_q.rf_idx] <= 1'b1;
      end
      rfv_a_q  <= rf_vld_q[rf_raddr_a];
      rfv_b_q  <= rf_vld_q[rf_raddr_b];
      wb_vld_q <= rf_we;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q  <= cmd_i;
      s1_dest_q <= RF_AW'(dest_reg_i);
      s1_ra_q   <= RF_AW'(src_a_reg_i);
      s1_rb_q   <= RF_AW'(src_b_reg_i);
      s1_imm_q  <= immediate_i;
    end
    if (en2) begin
      s2_q <= ex_res;
    end
    wb_idx_q  <= s2_q.rf_idx;
    wb_data_q <= s2_value;
    if (en_out) begin
      out_pc_q    <= s2_q.next_pc;
      out_rw_q    <= s2_q.reg_write;
      out_ridx_q  <= 4'(s2_q.rf_idx);
      out_rval_q  <= s2_value;
      out_mw_q    <= s2_q.mem_write;
      out_maddr_q <= s2_q.mem_addr;
      out_mval_q  <= s2_q.mem_value;
      out_halt_q  <= s2_q.halted;
    end
  end

  assign out_valid_o = out_vld_q;
  assign next_pc_o   = out_pc_q;
  assign reg_write_o = out_rw_q;
  assign reg_index_o = out_ridx_q;
  assign reg_value_o = out_rval_q;
  assign mem_write_o = out_mw_q;
  assign mem_addr_o  = out_maddr_q;
  assign mem_value_o = out_mval_q;
  assign halted_o    = out_halt_q;

  // no instruction enters while memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> !in_ready_o)
    else $error("input taken during memory clear");

  // halt is sticky and freezes the program counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && $stable(pc_q))
    else $error("state changed after halt");

  // a store only lands when execute hands over to the memory stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dm_we && !clr_active) |-> (s1_vld_q && en2 && !halt_q))
    else $error("stray data memory write");

  // register write back only from a valid memory stage word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (s2_vld_q && !s2_q.mem_write))
    else $error("stray register write");

  // a result reaching the output came from the memory stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s2_vld_q))
    else $error("result without an instruction");

endmodule

// ----- dv/small_risc_instruction_executor_top_test.sv -----
`timescale 1ns / 1ps

module small_risc_instruction_executor_top_test;
  import sri_pkg::*;

  // spare opcodes that the block treats as no-ops
  localparam logic [3:0] CMD_SPARE_LO = 4'd13;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int WORDS_PER_PHASE = 200;
  localparam int N_LEAD = 25;
  localparam int N_ROWS = 29;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [3:0]  rd;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [15:0] imm;
  } instr_t;

  typedef struct packed {
    logic [15:0] npc;
    logic        rw;
    logic [3:0]  ridx;
    logic [31:0] rval;
    logic        mw;
    logic [11:0] maddr;
    logic [31:0] mval;
    logic        halted;
  } outcome_t;

  typedef struct packed {
    instr_t   w;
    logic     has_exp;
    outcome_t exp;
  } stim_row_t;

  localparam outcome_t NO_EXP = '0;

  // directed rows; the last four run after the random part, from halt onward
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{'{CMD_MOVC, 4'd1, 4'd0, 4'd0, 16'h7fff}, 1'b1,
      '{16'd4004, 1'b1, 4'd1, 32'h0000_7fff, 1'b0, 12'd0, 32'd0, 1'b0}},
    '{'{CMD_MOVC, 4'd2, 4'd0, 4'd0, 16'h8000}, 1'b1,
      '{16'd4008, 1'b1, 4'd2, 32'hffff_8000, 1'b0, 12'd0, 32'd0, 1'b0}},
    '{'{CMD_LOAD, 4'd3, 4'd0, 4'd0, 16'h0fff}, 1'b1,
      '{16'd4012, 1'b1, 4'd3, 32'd0, 1'b0, 12'd4095, 32'd0, 1'b0}},
    '{'{CMD_ADD, 4'd4, 4'd1, 4'd2, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_SUB, 4'd5, 4'd1, 4'd1, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_BZ, 4'd0, 4'd0, 4'd0, 16'hfff8}, 1'b0, NO_EXP},
    '{'{CMD_MUL, 4'd6, 4'd2, 4'd2, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_BNZ, 4'd0, 4'd0, 4'd0, 16'h7fff}, 1'b0, NO_EXP},
    '{'{CMD_BZ, 4'd0, 4'd0, 4'd0, 16'h0100}, 1'b0, NO_EXP},
    '{'{CMD_MOVC, 4'd7, 4'd0, 4'd0, 16'hffff}, 1'b0, NO_EXP},
    '{'{CMD_AND, 4'd8, 4'd7, 4'd2, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_OR, 4'd9, 4'd1, 4'd2, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_XOR, 4'd10, 4'd7, 4'd1, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_STORE, 4'd0, 4'd7, 4'd0, 16'h0fff}, 1'b0, NO_EXP},
    '{'{CMD_LOAD, 4'd11, 4'd0, 4'd0, 16'h0fff}, 1'b0, NO_EXP},
    '{'{CMD_STORE, 4'd0, 4'd1, 4'd7, 16'h0001}, 1'b0, NO_EXP},
    '{'{CMD_LOAD, 4'd15, 4'd2, 4'd0, 16'h8000}, 1'b0, NO_EXP},
    '{'{CMD_MUL, 4'd12, 4'd0, 4'd1, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_BNZ, 4'd0, 4'd0, 4'd0, 16'h0040}, 1'b0, NO_EXP},
    '{'{CMD_JUMP, 4'd0, 4'd7, 4'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_JUMP, 4'd0, 4'd1, 4'd0, 16'h8001}, 1'b0, NO_EXP},
    '{'{CMD_BZ, 4'd0, 4'd0, 4'd0, 16'hfffc}, 1'b0, NO_EXP},
    '{'{CMD_SPARE_LO, 4'd3, 4'd1, 4'd2, 16'h1234}, 1'b0, NO_EXP},
    '{'{CMD_SPARE_HI, 4'd15, 4'd15, 4'd15, 16'hffff}, 1'b0, NO_EXP},
    '{'{CMD_MOVC, 4'd0, 4'd0, 4'd0, 16'h1234}, 1'b0, NO_EXP},
    '{'{CMD_HALT, 4'd0, 4'd0, 4'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{CMD_MOVC, 4'd3, 4'd0, 4'd0, 16'h0055}, 1'b0, NO_EXP},
    '{'{CMD_STORE, 4'd0, 4'd1, 4'd0, 16'h0010}, 1'b0, NO_EXP},
    '{'{CMD_HALT, 4'd0, 4'd0, 4'd0, 16'h0000}, 1'b0, NO_EXP}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [3:0]         cmd_i = '0;
  logic [3:0]         dest_reg_i = '0;
  logic [3:0]         src_a_reg_i = '0;
  logic [3:0]         src_b_reg_i = '0;
  logic signed [15:0] immediate_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        next_pc_o;
  logic               reg_write_o;
  logic [3:0]         reg_index_o;
  logic signed [31:0] reg_value_o;
  logic               mem_write_o;
  logic [11:0]        mem_addr_o;
  logic signed [31:0] mem_value_o;
  logic               halted_o;

  small_risc_instruction_executor_top dut (.*);

  // machine state mirrored by the predictor
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] dmem [DATA_WORDS];
  logic [15:0] pc;
  logic        zflag;
  logic        halt_seen;

  outcome_t retire_q [$];
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       mismatch_cnt = 0;
  int       words_sent = 0;
  int       results_checked = 0;
  int       loads_seen = 0;
  int       stores_seen = 0;
  int       redirects = 0;
  int       stall_cycles = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // execute one instruction against the mirrored state
  function automatic outcome_t retire_instr(instr_t w);
    outcome_t    r;
    logic [31:0] a, b, sx, sum;
    logic [15:0] npc;
    r = '0;
    a = gpr[w.ra];
    b = gpr[w.rb];
    sx = {{16{w.imm[15]}}, w.imm};
    if (halt_seen) begin
      r.npc = pc;
      r.halted = 1'b1;
      return r;
    end
    npc = pc + PC_STEP;
    case (w.cmd)
      CMD_MOVC: begin
        r.rw = 1'b1;
        r.rval = sx;
      end
      CMD_ADD: begin
        r.rw = 1'b1;
        r.rval = a + b;
        zflag = (r.rval == '0);
      end
      CMD_SUB: begin
        r.rw = 1'b1;
        r.rval = a - b;
        zflag = (r.rval == '0);
      end
      CMD_MUL: begin
        r.rw = 1'b1;
        r.rval = a * b;
        zflag = (r.rval == '0);
      end
      CMD_AND: begin
        r.rw = 1'b1;
        r.rval = a & b;
      end
      CMD_OR: begin
        r.rw = 1'b1;
        r.rval = a | b;
      end
      CMD_XOR: begin
        r.rw = 1'b1;
        r.rval = a ^ b;
      end
      CMD_LOAD: begin
        sum = a + sx;
        sum = sum % DATA_WORDS;
        r.rw = 1'b1;
        r.maddr = sum[11:0];
        r.rval = dmem[sum];
        loads_seen++;
      end
      CMD_STORE: begin
        sum = b + sx;
        sum = sum % DATA_WORDS;
        r.mw = 1'b1;
        r.maddr = sum[11:0];
        r.mval = a;
        dmem[sum] = a;
        stores_seen++;
      end
      CMD_BZ: begin
        if (zflag) begin
          npc = pc + w.imm;
          redirects++;
        end
      end
      CMD_BNZ: begin
        if (!zflag) begin
          npc = pc + w.imm;
          redirects++;
        end
      end
      CMD_JUMP: begin
        npc = 16'(a + sx);
        redirects++;
      end
      CMD_HALT: begin
        halt_seen = 1'b1;
        npc = pc;
      end
      default: ;
    endcase
    if (r.rw) begin
      gpr[w.rd] = r.rval;
      r.ridx = w.rd;
    end
    pc = npc;
    r.npc = npc;
    r.halted = halt_seen;
    return r;
  endfunction

  // half the picks come from a few registers so that hazards stay frequent
  function automatic logic [3:0] pick_reg();
    return 4'($urandom_range(1) ? $urandom_range(3) : $urandom_range(15));
  endfunction

  // random instruction, never halt; loads and stores often hit a small window
  function automatic instr_t rand_instr();
    instr_t      w;
    logic [11:0] base;
    w.cmd = 4'($urandom_range(15));
    if (w.cmd == CMD_HALT) w.cmd = CMD_MOVC;
    w.rd = pick_reg();
    w.ra = pick_reg();
    w.rb = pick_reg();
    w.imm = 16'($urandom);
    if (w.cmd == CMD_MOVC && $urandom_range(3) == 0) begin
      w.imm = 16'(int'($urandom_range(2)) - 1);
    end
    if ((w.cmd == CMD_LOAD || w.cmd == CMD_STORE) && $urandom_range(9) < 6) begin
      base = (w.cmd == CMD_LOAD) ? gpr[w.ra][11:0] : gpr[w.rb][11:0];
      w.imm[11:0] = 12'($urandom_range(15)) - base;
    end
    return w;
  endfunction

  // drive one word and record its expected result once accepted
  task automatic issue(input stim_row_t row);
    outcome_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= row.w.cmd;
    dest_reg_i  <= row.w.rd;
    src_a_reg_i <= row.w.ra;
    src_b_reg_i <= row.w.rb;
    immediate_i <= row.w.imm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = retire_instr(row.w);
    retire_q.push_back(row.has_exp ? row.exp : want);
    words_sent++;
  endtask

  // hold the sender off until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (retire_q.size() == 0) begin
        $display("%0t: result with nothing expected, next_pc %0h", $time, next_pc_o);
        mismatch_cnt++;
      end else begin
        want = retire_q.pop_front();
        results_checked++;
        check_field("next_pc", 32'(want.npc), 32'(next_pc_o));
        check_field("reg_write", 32'(want.rw), 32'(reg_write_o));
        check_field("reg_index", 32'(want.ridx), 32'(reg_index_o));
        check_field("reg_value", want.rval, reg_value_o);
        check_field("mem_write", 32'(want.mw), 32'(mem_write_o));
        check_field("mem_addr", 32'(want.maddr), 32'(mem_addr_o));
        check_field("mem_value", want.mval, mem_value_o);
        check_field("halted", 32'(want.halted), 32'(halted_o));
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("small_risc_instruction_executor_top_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int tx_tbl [4];
    int rx_tbl [4];
    tx_tbl = '{0, 69, 0, 20};
    rx_tbl = '{0, 0, 69, 20};
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc = PC_RESET;
    zflag = 1'b0;
    halt_seen = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed lead-in
    for (int i = 0; i < N_LEAD; i++) issue(DIRECTED[i]);
    drain();

    // random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  <= tx_tbl[ph];
      rx_stall_pct <= rx_tbl[ph];
      for (int n = 0; n < WORDS_PER_PHASE; n++) issue('{rand_instr(), 1'b0, NO_EXP});
      drain();
    end

    // halt and the words that follow it
    for (int i = N_LEAD; i < N_ROWS; i++) issue(DIRECTED[i]);
    drain();
    repeat (8) @(posedge clk_i);

    $display("sent %0d words, checked %0d results", words_sent, results_checked);
    $display("covered %0d loads, %0d stores, %0d taken branches or jumps",
             loads_seen, stores_seen, redirects);
    if (mismatch_cnt == 0) begin
      $display("small_risc_instruction_executor_top_test OK");
    end else begin
      $display("small_risc_instruction_executor_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sri_pkg.sv
hw/rtl/sri_ram.sv
hw/rtl/sri_exec.sv
hw/rtl/small_risc_instruction_executor_top.sv
dv/small_risc_instruction_executor_top_test.sv
